[hw/rtl/alm_pkg.sv]
// Shared constants, types and a helper function of the array linked list manager.
package alm_pkg;

    localparam int NODE_COUNT = 32;
    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PTR_W      = IDX_W + 1;
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FIND       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // A node index with a valid flag; a cleared flag means null.
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } ptr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_WALK_TAIL,
        S_WALK,
        S_RELEASE,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                start_take;
        logic                start_walk;
        logic                advance;
        logic                take_front;
        logic                take_back;
        logic                link_tail;
        logic                unlink;
        logic                release_node;
        logic                clear;
        logic                set_status;
        logic [STATUS_W-1:0] status_val;
        logic                set_pos;
        logic                out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                free_ok;
        logic                head_ok;
        logic                link_ok;
        logic                match;
        logic                tail_more;
        logic                walk_more;
        logic                out_free;
    } stat_t;

    // Link of a node that has not been written since the last clear:
    // entry i points to i+1, and the last entry is null.
    function automatic ptr_t link_default(input logic [IDX_W-1:0] idx);
        int unsigned nxt;
        ptr_t        p;
        nxt   = int'(idx) + 1;
        p.ok  = (nxt < NODE_COUNT);
        p.idx = IDX_W'(nxt);
        return p;
    endfunction

endpackage

[hw/rtl/array_linked_list_manager.sv]
// Top level of the array linked list manager: controller plus datapath.
// Clear, a full push and an unused opcode need no list walk; push front takes a free
// node, push back also walks to the tail, and find and remove walk from the head
// until a match or the end of the list. The next request is taken in the cycle after
// the result is loaded. Reset is synchronous, active low, and empties the list.
module array_linked_list_manager (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [alm_pkg::OPCODE_W-1:0]       s_opcode,
    input  logic signed [alm_pkg::VALUE_W-1:0] s_item_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [alm_pkg::STATUS_W-1:0]       m_status,
    output logic [alm_pkg::POS_W-1:0]          m_found_position,
    output logic [alm_pkg::COUNT_W-1:0]        m_entry_count
);

    // The controller issues one command set per cycle and the datapath answers with
    // flags about the list pointers, the node just read and the result register.
    alm_pkg::cmd_t  cmd;
    alm_pkg::stat_t stat;

    // The controller takes a new request whenever it is idle. A finished result sits in
    // the datapath's output register, so the next request can be taken and worked on
    // while the previous result still waits for the downstream side.
    alm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the node value and link memories, the head and free-list
    // pointers, the entry count and the walk cursor. Links that were never written since
    // the last clear read as the rebuilt free chain, tracked by one valid bit per node.
    // This is why reset needs no clearing pass over the link memory.
    alm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_item_value     (s_item_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

endmodule

[hw/rtl/alm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/alm_datapath.sv]
// Datapath of the list manager: node memories, list pointers, counters and result register.
module alm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  alm_pkg::cmd_t                 cmd,
    output alm_pkg::stat_t                stat,
    input  logic [alm_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic signed [alm_pkg::VALUE_W-1:0] s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [alm_pkg::STATUS_W-1:0]  m_status,
    output logic [alm_pkg::POS_W-1:0]     m_found_position,
    output logic [alm_pkg::COUNT_W-1:0]   m_entry_count
);

    localparam int IDX_W = alm_pkg::IDX_W;
    localparam int CNT_W = alm_pkg::CNT_W;

    logic [alm_pkg::OPCODE_W-1:0] op_reg;
    logic [alm_pkg::VALUE_W-1:0]  val_reg;
    alm_pkg::ptr_t                head_reg, head_next;
    alm_pkg::ptr_t                free_reg, free_next;
    logic [CNT_W-1:0]             size_reg, size_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    alm_pkg::ptr_t                prev_reg, prev_next;
    logic [CNT_W-1:0]             steps_reg, steps_next;
    logic [IDX_W-1:0]             new_reg;
    logic [alm_pkg::STATUS_W-1:0] status_reg;
    logic [alm_pkg::POS_W-1:0]    pos_reg;
    logic [alm_pkg::NODE_COUNT-1:0] written_reg;

    logic                         out_valid_reg;
    logic [alm_pkg::STATUS_W-1:0] out_status_reg;
    logic [alm_pkg::POS_W-1:0]    out_pos_reg;
    logic [alm_pkg::COUNT_W-1:0]  out_count_reg;

    logic                         link_we;
    logic [IDX_W-1:0]             link_waddr;
    alm_pkg::ptr_t                link_wdata;
    logic [IDX_W-1:0]             raddr;
    logic [IDX_W-1:0]             raddr_reg;
    logic                         rd_written_reg;
    logic [alm_pkg::PTR_W-1:0]    link_rdata;
    alm_pkg::ptr_t                link_out;
    logic                         val_we;
    logic [alm_pkg::VALUE_W-1:0]  val_rdata;

    alm_ram #(.WIDTH(alm_pkg::PTR_W), .DEPTH(alm_pkg::NODE_COUNT)) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    alm_ram #(.WIDTH(alm_pkg::VALUE_W), .DEPTH(alm_pkg::NODE_COUNT)) u_value_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (free_reg.idx),
        .wdata (val_reg),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    // An entry not written since the last clear reads as its rebuilt free-chain link.
    assign link_out = rd_written_reg ? alm_pkg::ptr_t'(link_rdata)
                                     : alm_pkg::link_default(raddr_reg);

    always_comb begin
        if (cmd.start_take) begin
            raddr = free_reg.idx;
        end else if (cmd.start_walk) begin
            raddr = head_reg.idx;
        end else if (cmd.advance) begin
            raddr = link_out.idx;
        end else begin
            raddr = cur_reg;
        end
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = link_out;
        if (cmd.take_front) begin
            link_we    = 1'b1;
            link_waddr = free_reg.idx;
            link_wdata = head_reg;
        end else if (cmd.take_back) begin
            link_we    = 1'b1;
            link_waddr = free_reg.idx;
            link_wdata = '0;
        end else if (cmd.link_tail) begin
            link_we    = 1'b1;
            link_wdata = '{ok: 1'b1, idx: new_reg};
        end else if (cmd.unlink && prev_reg.ok) begin
            link_we    = 1'b1;
            link_waddr = prev_reg.idx;
        end else if (cmd.release_node) begin
            link_we    = 1'b1;
            link_wdata = free_reg;
        end
    end

    assign val_we = cmd.take_front | cmd.take_back;

    always_comb begin
        head_next  = head_reg;
        free_next  = free_reg;
        size_next  = size_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        if (cmd.clear) begin
            head_next = '0;
            free_next = '{ok: 1'b1, idx: '0};
            size_next = '0;
        end
        if (cmd.take_front || cmd.take_back) begin
            free_next = link_out;
            size_next = size_reg + 1'b1;
            if (cmd.take_front || !head_reg.ok) begin
                head_next = '{ok: 1'b1, idx: free_reg.idx};
            end
        end
        if (cmd.unlink && !prev_reg.ok) begin
            head_next = link_out;
        end
        if (cmd.release_node) begin
            free_next = '{ok: 1'b1, idx: cur_reg};
            if (size_reg != '0) begin
                size_next = size_reg - 1'b1;
            end
        end
        if (cmd.start_walk) begin
            cur_next   = head_reg.idx;
            prev_next  = '0;
            steps_next = '0;
        end else if (cmd.advance) begin
            cur_next   = link_out.idx;
            prev_next  = '{ok: 1'b1, idx: cur_reg};
            steps_next = steps_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            free_reg      <= '{ok: 1'b1, idx: '0};
            size_reg      <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            free_reg <= free_next;
            size_reg <= size_next;
            if (cmd.clear) begin
                written_reg <= '0;
            end else if (link_we) begin
                written_reg[link_waddr] <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        raddr_reg      <= raddr;
        rd_written_reg <= written_reg[raddr];
        if (cmd.load) begin
            op_reg     <= s_opcode;
            val_reg    <= s_item_value;
            status_reg <= alm_pkg::ST_OK;
            pos_reg    <= '0;
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status_val;
            end
            if (cmd.set_pos) begin
                pos_reg <= alm_pkg::POS_W'(steps_reg);
            end
        end
        if (cmd.take_back) begin
            new_reg <= free_reg.idx;
        end
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_pos_reg    <= pos_reg;
            out_count_reg  <= alm_pkg::COUNT_W'(size_reg);
        end
    end

    assign stat.op        = op_reg;
    assign stat.free_ok   = free_reg.ok;
    assign stat.head_ok   = head_reg.ok;
    assign stat.link_ok   = link_out.ok;
    assign stat.match     = (val_rdata == val_reg);
    assign stat.tail_more = (steps_reg < CNT_W'(alm_pkg::NODE_COUNT));
    assign stat.walk_more = (({1'b0, steps_reg} + 1'b1) < (CNT_W + 1)'(alm_pkg::NODE_COUNT));
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_found_position = out_pos_reg;
    assign m_entry_count    = out_count_reg;

endmodule

[hw/rtl/alm_controller.sv]
// Controller state machine that sequences each list operation through the datapath.
module alm_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  alm_pkg::stat_t stat,
    output alm_pkg::cmd_t  cmd
);

    alm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            alm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = alm_pkg::S_DECODE;
                end
            end
            alm_pkg::S_DECODE: begin
                state_next = alm_pkg::S_FINISH;
                unique case (stat.op) inside
                    alm_pkg::OP_PUSH_FRONT, alm_pkg::OP_PUSH_BACK: begin
                        if (!stat.free_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = alm_pkg::ST_FULL;
                        end else begin
                            cmd.start_take = 1'b1;
                            state_next     = alm_pkg::S_TAKE;
                        end
                    end
                    alm_pkg::OP_REMOVE, alm_pkg::OP_FIND: begin
                        if (!stat.head_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = alm_pkg::ST_MISS;
                        end else begin
                            cmd.start_walk = 1'b1;
                            state_next     = alm_pkg::S_WALK;
                        end
                    end
                    alm_pkg::OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            alm_pkg::S_TAKE: begin
                state_next = alm_pkg::S_FINISH;
                if (stat.op == alm_pkg::OP_PUSH_FRONT) begin
                    cmd.take_front = 1'b1;
                end else begin
                    cmd.take_back = 1'b1;
                    if (stat.head_ok) begin
                        cmd.start_walk = 1'b1;
                        state_next     = alm_pkg::S_WALK_TAIL;
                    end
                end
            end
            alm_pkg::S_WALK_TAIL: begin
                if (stat.link_ok && stat.tail_more) begin
                    cmd.advance = 1'b1;
                end else begin
                    cmd.link_tail = 1'b1;
                    state_next    = alm_pkg::S_FINISH;
                end
            end
            alm_pkg::S_WALK: begin
                if (stat.match) begin
                    if (stat.op == alm_pkg::OP_FIND) begin
                        cmd.set_pos = 1'b1;
                        state_next  = alm_pkg::S_FINISH;
                    end else begin
                        cmd.unlink = 1'b1;
                        state_next = alm_pkg::S_RELEASE;
                    end
                end else if (stat.link_ok && stat.walk_more) begin
                    cmd.advance = 1'b1;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = alm_pkg::ST_MISS;
                    state_next     = alm_pkg::S_FINISH;
                end
            end
            alm_pkg::S_RELEASE: begin
                cmd.release_node = 1'b1;
                state_next       = alm_pkg::S_FINISH;
            end
            alm_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = alm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = alm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/alm_checker.sv]
// Port-level checker for the array linked list manager, bound to the top level.
module alm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [alm_pkg::STATUS_W-1:0]       m_status,
    input logic [alm_pkg::POS_W-1:0]          m_found_position,
    input logic [alm_pkg::COUNT_W-1:0]        m_entry_count
);

    // A stalled result must hold its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_found_position) && $stable(m_entry_count))
        else $error("result changed while stalled");

    // A full status is only reported when every node is in use.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == alm_pkg::ST_FULL |->
        m_entry_count == alm_pkg::COUNT_W'(alm_pkg::NODE_COUNT))
        else $error("full status with free nodes left");

    // A nonzero position only comes with a successful find.
    a_pos_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found_position != '0 |-> m_status == alm_pkg::ST_OK)
        else $error("position reported without a match");

    // An accepted request keeps the input closed on the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_found_position (m_found_position),
    .m_entry_count    (m_entry_count)
);
